>>> rtl/plit_pkg.sv
// plit_pkg: operation and status codes, field widths and defaults
// for the interpolation table unit; no dependencies
`timescale 1ns / 1ps
package plit_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int OP_W     = 2;
    localparam int KEY_W    = 8;
    localparam int COUNT_W  = 16;
    localparam int QUERY_W  = 16;
    localparam int RATIO_W  = 17;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ORDER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd4;
endpackage

>>> rtl/plit_if.sv
// plit_in_if and plit_out_if: valid/ready channels of the table unit
// depends on plit_pkg
`timescale 1ns / 1ps
interface plit_in_if;
    logic                           valid;
    logic                           ready;
    logic [plit_pkg::OP_W-1:0]      operation;
    logic [plit_pkg::KEY_W-1:0]     entry_key;
    logic [plit_pkg::COUNT_W-1:0]   pos_count;
    logic [plit_pkg::COUNT_W-1:0]   neg_count;
    logic [plit_pkg::QUERY_W-1:0]   query_value;
    modport source (output valid, operation, entry_key, pos_count, neg_count, query_value,
                    input ready);
    modport sink (input valid, operation, entry_key, pos_count, neg_count, query_value,
                  output ready);
endinterface

interface plit_out_if;
    logic                           valid;
    logic                           ready;
    logic [plit_pkg::RATIO_W-1:0]   ratio;
    logic [plit_pkg::STATUS_W-1:0]  status;
    modport source (output valid, ratio, status, input ready);
    modport sink (input valid, ratio, status, output ready);
endinterface

>>> rtl/piecewise_linear_interpolation_table_unit.sv
// piecewise_linear_interpolation_table_unit: key/ratio table in one synchronous
// memory, linear search and a shared restoring divider
// depends on plit_pkg and plit_if
//
// channel | dir | handshake       | payload
// i_in    | in  | valid && ready  | operation, entry_key, pos_count, neg_count, query_value
// o_out   | out | valid && ready  | ratio, status
//
// clear, reserved code, flagged appends and flagged queries: result valid in the cycle after acceptance
// append: ratio formed by the divider in S_DIV, entry written, then S_FIN loads the result register once it is free
// query: S_RD and S_CMP for each entry scanned (up to all entries), then S_MUL and the
// divider when interpolating, and S_FIN as for append
// one item in flight; the next is taken once the result register is free
// synchronous active-low reset clears control and the entry count; memory is not cleared
`timescale 1ns / 1ps
module piecewise_linear_interpolation_table_unit #(
    parameter int TABLE_DEPTH = plit_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    plit_in_if.sink      i_in,
    plit_out_if.source   o_out
);
    import plit_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = KEY_W + RATIO_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [MW-1:0] mem [TABLE_DEPTH];
    logic [MW-1:0] r_rd;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [KEY_W-1:0]    r_last, n_last;
    logic [AW-1:0]       r_idx, n_idx;
    logic [QUERY_W-1:0]  r_q, n_q;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_k0, n_k0;
    logic [KEY_W-1:0]    r_k1, n_k1;
    logic [RATIO_W-1:0]  r_r0, n_r0;
    logic [RATIO_W-1:0]  r_mag, n_mag;
    logic [QUERY_W-1:0]  r_d, n_d;
    logic                r_neg, n_neg;
    logic                r_mode, n_mode;
    logic [31:0]         r_dvd, n_dvd;
    logic [16:0]         r_dvs, n_dvs;
    logic [17:0]         r_rem, n_rem;
    logic [31:0]         r_quo, n_quo;
    logic [4:0]          r_step, n_step;
    logic                r_ovalid, n_ovalid;
    logic [RATIO_W-1:0]  r_oratio, n_oratio;
    logic [STATUS_W-1:0] r_ostatus, n_ostatus;
    logic [RATIO_W-1:0]  r_res, n_res;
    logic [STATUS_W-1:0] r_rst, n_rst;

    logic            w_we;
    logic [AW-1:0]   w_wa;
    logic [MW-1:0]   w_wd;

    logic            slot_free;
    logic            in_acc;
    logic [17:0]     rem_sh;
    logic            ge;
    logic [17:0]     rem_nx;
    logic [31:0]     quo_nx;
    logic [16:0]     sum;
    logic [KEY_W-1:0]   rd_key;
    logic [RATIO_W-1:0] rd_ratio;
    logic            gt;
    logic            at_last;
    logic [17:0]     diff;
    logic [32:0]     prod;

    assign slot_free   = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && slot_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.ratio = r_oratio;
    assign o_out.status = r_ostatus;

    assign rem_sh   = {r_rem[16:0], r_dvd[31]};
    assign ge       = rem_sh >= {1'b0, r_dvs};
    assign rem_nx   = ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
    assign quo_nx   = {r_quo[30:0], ge};
    assign sum      = {1'b0, i_in.pos_count} + {1'b0, i_in.neg_count};
    assign rd_key   = r_rd[MW-1:RATIO_W];
    assign rd_ratio = r_rd[RATIO_W-1:0];
    assign gt       = r_q > {rd_key, 8'h00};
    assign at_last  = (CW'(r_idx) + CW'(1)) == r_cnt;
    assign diff     = {1'b0, rd_ratio} - {1'b0, r_r0};
    assign prod     = r_d * r_mag;

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;   n_last = r_last;  n_idx = r_idx;
        n_q = r_q;           n_key = r_key;   n_k0 = r_k0;      n_k1 = r_k1;
        n_r0 = r_r0;         n_mag = r_mag;   n_d = r_d;        n_neg = r_neg;
        n_mode = r_mode;     n_dvd = r_dvd;   n_dvs = r_dvs;    n_rem = r_rem;
        n_quo = r_quo;       n_step = r_step; n_res = r_res;    n_rst = r_rst;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oratio = r_oratio; n_ostatus = r_ostatus;
        w_we = 1'b0;
        w_wa = r_cnt[AW-1:0];
        w_wd = {r_key, quo_nx[RATIO_W-1:0]};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_oratio  = '0;
                    n_ostatus = ST_OK;
                    unique case (i_in.operation)
                        OP_CLEAR: begin
                            n_cnt = '0;
                            n_ovalid = 1'b1;
                        end
                        OP_APPEND: begin
                            if (r_cnt == CW'(TABLE_DEPTH)) begin
                                n_ostatus = ST_FULL;
                                n_ovalid  = 1'b1;
                            end else if (r_cnt != '0 && i_in.entry_key <= r_last) begin
                                n_ostatus = ST_ORDER;
                                n_ovalid  = 1'b1;
                            end else if (sum == '0) begin
                                w_we = 1'b1;
                                w_wd = {i_in.entry_key, {RATIO_W{1'b0}}};
                                n_cnt = r_cnt + CW'(1);
                                n_last = i_in.entry_key;
                                n_ostatus = ST_ZERO;
                                n_ovalid  = 1'b1;
                            end else begin
                                n_key  = i_in.entry_key;
                                n_mode = 1'b0;
                                n_dvd  = {i_in.pos_count, 16'h0000};
                                n_dvs  = sum;
                                n_rem  = '0;
                                n_quo  = '0;
                                n_step = '0;
                                n_state = S_DIV;
                            end
                        end
                        OP_QUERY: begin
                            if (r_cnt == '0) begin
                                n_ostatus = ST_EMPTY;
                                n_ovalid  = 1'b1;
                            end else begin
                                n_q = i_in.query_value;
                                n_idx = '0;
                                n_state = S_RD;
                            end
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (gt) begin
                    if (at_last) begin
                        n_res = rd_ratio;
                        n_rst = ST_OK;
                        n_state = S_FIN;
                    end else begin
                        n_k0 = rd_key;
                        n_r0 = rd_ratio;
                        n_idx = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end else if (r_idx == '0) begin
                    n_res = rd_ratio;
                    n_rst = ST_OK;
                    n_state = S_FIN;
                end else begin
                    n_k1  = rd_key;
                    n_neg = diff[17];
                    n_mag = diff[17] ? RATIO_W'(-diff) : diff[RATIO_W-1:0];
                    n_d   = r_q - {r_k0, 8'h00};
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_mode = 1'b1;
                n_dvd  = {7'b0, prod[32:8]};
                n_dvs  = {9'b0, r_k1 - r_k0};
                n_rem  = '0;
                n_quo  = '0;
                n_step = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_dvd  = {r_dvd[30:0], 1'b0};
                n_rem  = rem_nx;
                n_quo  = quo_nx;
                n_step = r_step + 5'd1;
                if (r_step == 5'd31) begin
                    n_rst = ST_OK;
                    if (r_mode) begin
                        n_res = r_neg ? r_r0 - quo_nx[RATIO_W-1:0]
                                      : r_r0 + quo_nx[RATIO_W-1:0];
                    end else begin
                        n_res = '0;
                        w_we  = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                        n_last = r_key;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_oratio  = r_res;
                    n_ostatus = r_rst;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;  r_idx <= n_idx;   r_q <= n_q;       r_key <= n_key;
        r_k0 <= n_k0;      r_k1 <= n_k1;     r_r0 <= n_r0;     r_mag <= n_mag;
        r_d <= n_d;        r_neg <= n_neg;   r_mode <= n_mode; r_dvd <= n_dvd;
        r_dvs <= n_dvs;    r_rem <= n_rem;   r_quo <= n_quo;   r_step <= n_step;
        r_oratio <= n_oratio; r_ostatus <= n_ostatus; r_res <= n_res; r_rst <= n_rst;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_DEPTH)) else $error("entry count beyond depth");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != $past(r_cnt) |-> r_cnt == '0 || r_cnt == $past(r_cnt) + CW'(1))
        else $error("entry count jumped");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < {1'b0, r_dvs}) else $error("divider remainder too large");

    a_busy_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_state == S_IDLE && slot_free) else $error("item taken while busy");
endmodule

>>> tb/plit_checker.sv
// plit_checker: watches both channels of the interpolation table unit, keeps its own
// copy of the table, predicts every result and compares it field by field
// depends on plit_pkg and plit_if
`timescale 1ns / 1ps
module plit_checker #(
    parameter int TABLE_DEPTH = plit_pkg::TABLE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    plit_in_if   i_in,
    plit_out_if  i_out,
    output int   o_errors,
    output int   o_pending
);
    import plit_pkg::*;

    typedef struct packed {
        logic [RATIO_W-1:0]  ratio;
        logic [STATUS_W-1:0] status;
    } t_table_result;

    logic [KEY_W-1:0]   keys   [TABLE_DEPTH];
    logic [RATIO_W-1:0] ratios [TABLE_DEPTH];
    int                 n_entries;
    t_table_result      expected_results [$];

    function automatic logic [RATIO_W-1:0] entry_ratio(input longint p, input longint n);
        if (p + n == 0) return '0;
        return RATIO_W'((p << 16) / (p + n));
    endfunction

    function automatic logic [RATIO_W-1:0] interpolate(input longint q);
        int     i;
        longint k0, k1, r0, r1, v;
        i = 0;
        while (i < n_entries && q > (longint'(keys[i]) << 8)) i++;
        if (i == 0) return ratios[0];
        if (i >= n_entries) return ratios[n_entries-1];
        k0 = longint'(keys[i-1]) << 8;
        k1 = longint'(keys[i]) << 8;
        r0 = longint'(ratios[i-1]);
        r1 = longint'(ratios[i]);
        v  = r0 + ((q - k0) * (r1 - r0)) / (k1 - k0);
        if (v < 0) v = 0;
        if (v > 65536) v = 65536;
        return RATIO_W'(v);
    endfunction

    function automatic t_table_result apply_item(input logic [OP_W-1:0] op,
            input logic [KEY_W-1:0] key, input logic [COUNT_W-1:0] p,
            input logic [COUNT_W-1:0] n, input logic [QUERY_W-1:0] q);
        t_table_result r;
        r = '{ratio: '0, status: ST_OK};
        case (op)
            OP_CLEAR: n_entries = 0;
            OP_APPEND: begin
                if (n_entries >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else if (n_entries > 0 && key <= keys[n_entries-1]) begin
                    r.status = ST_ORDER;
                end else begin
                    if (p == 0 && n == 0) r.status = ST_ZERO;
                    keys[n_entries]   = key;
                    ratios[n_entries] = entry_ratio(longint'(p), longint'(n));
                    n_entries++;
                end
            end
            OP_QUERY: begin
                if (n_entries == 0) r.status = ST_EMPTY;
                else r.ratio = interpolate(longint'(q));
            end
            default: ;
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_table_result exp_r;
        if (!i_rst_n) begin
            n_entries = 0;
        end else begin
            if (i_in.valid && i_in.ready)
                expected_results.insert(expected_results.size(),
                    apply_item(i_in.operation, i_in.entry_key,
                    i_in.pos_count, i_in.neg_count, i_in.query_value));
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected item: ratio %0d status %0d", i_out.ratio, i_out.status);
                    o_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_out.ratio !== exp_r.ratio) begin
                        $error("ratio: expected %0d, got %0d", exp_r.ratio, i_out.ratio);
                        o_errors++;
                    end
                    if (i_out.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, i_out.status);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

>>> tb/piecewise_linear_interpolation_table_unit_tb.sv
// piecewise_linear_interpolation_table_unit_tb: drives clears, appends, queries and the reserved code into
// the table unit under bursty input and stalling output; plit_checker does the checking
// depends on plit_pkg, plit_if, plit_checker and the unit itself
`timescale 1ns / 1ps
module piecewise_linear_interpolation_table_unit_tb;
    import plit_pkg::*;

    localparam int N_ITEMS  = 550;
    localparam int WD_LIMIT = 8000;
    localparam int LONG_HOLD = 600;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   burst_left, items_sent, wd_count;
    int   hold_req, hold_done;
    logic [KEY_W-1:0] last_key;
    int   n_keys;

    plit_in_if  in_if ();
    plit_out_if out_if ();

    piecewise_linear_interpolation_table_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    plit_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .i_out     (out_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            wd_count <= 0;
        end else if (wd_count >= WD_LIMIT) begin
            $display("piecewise_linear_interpolation_table_unit_tb: errors");
            $finish;
        end else begin
            wd_count <= wd_count + 1;
        end
    end

    // receiver: stall pattern chosen at random anew for each stretch, long hold-off on request
    initial begin
        int mode;
        hold_done = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req != hold_done) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done++;
            end
            mode = $urandom_range(0, 3);
            repeat (64) begin
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 1) == 1);
                    2: out_if.ready <= ($urandom_range(0, 4) == 0);
                    default: out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
            input logic [COUNT_W-1:0] p, input logic [COUNT_W-1:0] n,
            input logic [QUERY_W-1:0] q);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_if.valid       <= 1'b1;
        in_if.operation   <= op;
        in_if.entry_key   <= key;
        in_if.pos_count   <= p;
        in_if.neg_count   <= n;
        in_if.query_value <= q;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic append_next(input bit broken);
        logic [KEY_W-1:0] k;
        logic [COUNT_W-1:0] p, n;
        if (broken || last_key == 8'hFF)
            k = KEY_W'($urandom_range(0, 255));
        else if (n_keys == 0)
            k = KEY_W'($urandom_range(0, 200));
        else
            k = KEY_W'($urandom_range(last_key + 1,
                    (last_key + 40 > 255) ? 255 : last_key + 40));
        case ($urandom_range(0, 3))
            0: begin
                p = COUNT_W'($urandom_range(0, 20));
                n = COUNT_W'($urandom_range(0, 20));
            end
            1: begin p = COUNT_W'($urandom()); n = '0; end
            default: begin p = COUNT_W'($urandom()); n = COUNT_W'($urandom()); end
        endcase
        if (n_keys == 0 || k > last_key) begin
            last_key = k;
            n_keys++;
        end
        send_item(OP_APPEND, k, p, n, QUERY_W'($urandom()));
    endtask

    task automatic random_query();
        logic [QUERY_W-1:0] q;
        case ($urandom_range(0, 3))
            0: q = QUERY_W'($urandom());
            1: q = {($urandom_range(0, 1) == 1) ? last_key : KEY_W'($urandom()), 8'h00};
            2: q = QUERY_W'({last_key, 8'h00} + $urandom_range(0, 600) - 300);
            default: q = QUERY_W'($urandom_range(0, {last_key, 8'hFF}));
        endcase
        send_item(OP_QUERY, KEY_W'($urandom()), COUNT_W'($urandom()),
                  COUNT_W'($urandom()), q);
    endtask

    initial begin
        int n_app;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.operation   <= OP_CLEAR;
        in_if.entry_key   <= '0;
        in_if.pos_count   <= '0;
        in_if.neg_count   <= '0;
        in_if.query_value <= '0;
        burst_left = 0;
        items_sent = 0;
        hold_req   = 0;
        last_key   = '0;
        n_keys     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, zero counts, extremes, order and unused code
        send_item(OP_QUERY, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(OP_APPEND, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_APPEND, 8'h05, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(OP_APPEND, 8'h05, 16'h0001, 16'h0001, 16'h0000);
        send_item(OP_APPEND, 8'h03, 16'h0001, 16'h0001, 16'h0000);
        send_item(OP_APPEND, 8'h40, 16'h0001, 16'h0002, 16'h0000);
        send_item(OP_APPEND, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0080);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0500);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0501);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h2000);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'hFF00);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(OP_RESERVED, 8'hAA, 16'h5555, 16'hAAAA, 16'h5A5A);
        send_item(OP_CLEAR, 8'h55, 16'hAAAA, 16'h5555, 16'hA5A5);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h1234);
        send_item(OP_APPEND, 8'h80, 16'h7FFF, 16'h8000, 16'h0000);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_QUERY, 8'h00, 16'h0000, 16'h0000, 16'hFFFF);
        drain_results();

        // full table, then appends past the end
        send_item(OP_CLEAR, '0, '0, '0, '0);
        for (int k = 0; k < TABLE_DEPTH_DEF; k++)
            send_item(OP_APPEND, KEY_W'(k), COUNT_W'($urandom()), COUNT_W'($urandom()), '0);
        send_item(OP_APPEND, 8'hFF, 16'h0001, 16'h0001, '0);
        send_item(OP_APPEND, 8'h00, 16'h0001, 16'h0001, '0);
        last_key = 8'hFF;
        n_keys   = TABLE_DEPTH_DEF;
        hold_req++;
        repeat (6) random_query();

        // random sequences: mostly clear, ascending appends, queries
        while (items_sent < N_ITEMS) begin
            if (items_sent > 400 && items_sent < 420) drain_results();
            if ($urandom_range(0, 5) != 0) begin
                send_item(OP_CLEAR, KEY_W'($urandom()), COUNT_W'($urandom()),
                          COUNT_W'($urandom()), QUERY_W'($urandom()));
                last_key = '0;
                n_keys   = 0;
            end
            n_app = $urandom_range(0, 10);
            for (int a = 0; a < n_app; a++)
                append_next($urandom_range(0, 11) == 0);
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(OP_RESERVED, KEY_W'($urandom()), COUNT_W'($urandom()),
                              COUNT_W'($urandom()), QUERY_W'($urandom()));
                else
                    random_query();
            end
        end

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("piecewise_linear_interpolation_table_unit_tb: clean");
        end else begin
            $display("piecewise_linear_interpolation_table_unit_tb: errors");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/plit_pkg.sv
rtl/plit_if.sv
rtl/piecewise_linear_interpolation_table_unit.sv
tb/plit_checker.sv
tb/piecewise_linear_interpolation_table_unit_tb.sv
